// ----- src/urc_pkg.sv -----
// ----------------------------------------------------------------------------
// urc_pkg: shared types and constants of the ultrasonic range controller
// Phase codes, register indexes, widths and the packed result layout.
// ----------------------------------------------------------------------------
package urc_pkg;

  // elapsed tick counter width
  localparam int ELAPSED_WIDTH = 24;
  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;
  localparam int PROD_WIDTH    = ELAPSED_WIDTH + 16;

  localparam int DIST_WIDTH    = 21;
  localparam int DIFF_WIDTH    = DIST_WIDTH + 1;
  localparam logic [DIST_WIDTH-1:0] Q8_CLAMP = DIST_WIDTH'(1048575 + 4096);
  localparam logic signed [DIFF_WIDTH-1:0] DIST_MAX = DIFF_WIDTH'(1048575);
  localparam logic signed [DIFF_WIDTH-1:0] DIST_MIN = -DIFF_WIDTH'(65536);

  localparam int APB_ADDR_WIDTH = 5;
  localparam int APB_DATA_WIDTH = 32;

  // configuration reset values
  localparam logic [15:0] CARRIER_PERIOD_RST = 16'd1200;
  localparam logic [3:0]  BURST_COUNT_RST    = 4'd8;
  localparam logic [23:0] TIMEOUT_RST        = 24'd1680000;
  localparam logic [15:0] CM_PER_TICK_RST    = 16'd5942;
  localparam logic [11:0] OFFSET_RST         = 12'd896;

  typedef enum logic [1:0] {
    PH_READY  = 2'd0,
    PH_BURST  = 2'd1,
    PH_LISTEN = 2'd2,
    PH_OVER   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_CARRIER_PERIOD = 3'd0,
    REG_BURST_COUNT    = 3'd1,
    REG_TIMEOUT        = 3'd2,
    REG_CM_PER_TICK    = 3'd3,
    REG_OFFSET         = 3'd4
  } reg_idx_e;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [2:0]            pad;
    logic [DIST_WIDTH-1:0] distance_q8;
    logic                  timed_out;
    logic                  done_res;
    logic [1:0]            phase;
    logic                  rx_enable;
    logic                  tx_power_on;
    logic                  tx_drive_b;
    logic                  tx_drive_a;
  } result_t;

endpackage

// ----- src/ultrasonic_range_controller.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_controller: time-of-flight ranging sequencer
// Burst generation, echo capture and distance computation, one tick per item.
// ----------------------------------------------------------------------------
// Usage: every transfer on the slave stream is one tick of the time base.
// s_axis_tuser carries the start command, s_axis_tdata[0] the sampled echo
// pin. Each accepted tick produces exactly one result transfer on the master
// stream with the carrier drives, power and receiver enables, the phase, a
// done strobe, the timeout flag and the last distance in Q8 centimetres.
// The result of a tick is registered and presented on the cycle after its
// transfer. Throughput is one tick per cycle unless the receiver stalls; the
// per-tick path is the 24x16 distance multiply, offset subtract and clamp.
// The result stage is a single output register: while the receiver stalls,
// s_axis_tready is low and the tick sequencer holds its state; a new tick is
// taken in the same cycle that the waiting result is taken.
// The APB port writes and reads the five configuration registers at byte
// addresses 0, 4, 8, 12 and 16; pready is always high. Write them only while
// no tick is in flight.
// Reset returns the configuration to its defaults, the phase to ready, all
// counters and the distance to zero, and the echo history to high.
// ----------------------------------------------------------------------------
module ultrasonic_range_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [0] echo_level
  input  logic                                s_axis_tuser,   // [0] command
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] tx_drive_a, [1] tx_drive_b, [2] tx_power_on, [3] rx_enable,
  // [5:4] phase, [6] done_res, [7] timed_out, [28:8] distance_q8
  output logic [31:0]                         m_axis_tdata,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [urc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [urc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [urc_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);
  import urc_pkg::*;

  // configuration registers
  logic [15:0] carrier_period_q;
  logic [3:0]  burst_count_q;
  logic [23:0] timeout_q;
  logic [15:0] cm_per_tick_q;
  logic [11:0] offset_q;

  // sequencer state
  phase_e                   phase_q, phase_d;
  logic [ELAPSED_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [15:0]              carrier_q, carrier_d;
  logic [3:0]               pulses_q, pulses_d;
  logic [DIST_WIDTH-1:0]    distance_q, distance_d;
  logic                     echo_prev_q;
  logic                     timed_out_q, timed_out_d;

  // output stage
  logic    out_valid_q;
  result_t out_q, out_d;

  logic                     accept;
  logic                     cfg_write;
  reg_idx_e                 cfg_idx;
  logic                     cmd, echo, falling, start, done;
  logic [ELAPSED_WIDTH-1:0] elapsed_inc;
  logic [16:0]              carrier_inc;
  logic [15:0]              period_eff;
  logic [3:0]               pulses_inc;
  logic [PROD_WIDTH-1:0]    product;
  logic [PROD_WIDTH-1:0]    q8_full;
  logic [DIST_WIDTH-1:0]    q8_sat;
  logic signed [DIFF_WIDTH-1:0] diff;
  logic [DIST_WIDTH-1:0]    dist_new;
  logic                     drive_a;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_period_q <= CARRIER_PERIOD_RST;
      burst_count_q    <= BURST_COUNT_RST;
      timeout_q        <= TIMEOUT_RST;
      cm_per_tick_q    <= CM_PER_TICK_RST;
      offset_q         <= OFFSET_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_CARRIER_PERIOD: carrier_period_q <= pwdata[15:0];
        REG_BURST_COUNT:    burst_count_q    <= pwdata[3:0];
        REG_TIMEOUT:        timeout_q        <= pwdata[23:0];
        REG_CM_PER_TICK:    cm_per_tick_q    <= pwdata[15:0];
        REG_OFFSET:         offset_q         <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CARRIER_PERIOD: prdata = {16'd0, carrier_period_q};
      REG_BURST_COUNT:    prdata = {28'd0, burst_count_q};
      REG_TIMEOUT:        prdata = {8'd0, timeout_q};
      REG_CM_PER_TICK:    prdata = {16'd0, cm_per_tick_q};
      REG_OFFSET:         prdata = {20'd0, offset_q};
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // tick sequencer
  // --------------------------------------------------------------------------
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd     = s_axis_tuser;
  assign echo    = s_axis_tdata[0];
  assign falling = echo_prev_q && !echo;
  assign start   = cmd && (phase_q inside {PH_READY, PH_OVER});

  // periods below two behave as two
  assign period_eff  = (carrier_period_q < 16'd2) ? 16'd2 : carrier_period_q;
  assign elapsed_inc = elapsed_q + ELAPSED_WIDTH'(elapsed_q != ELAPSED_MAX);
  assign carrier_inc = {1'b0, carrier_q} + 17'd1;
  assign pulses_inc  = pulses_q + 4'd1;

  // distance from the tick count of this tick
  assign product = PROD_WIDTH'(elapsed_inc) * PROD_WIDTH'(cm_per_tick_q);
  assign q8_full = product >> 16;
  assign q8_sat  = (q8_full > PROD_WIDTH'(Q8_CLAMP)) ? Q8_CLAMP
                                                     : q8_full[DIST_WIDTH-1:0];
  assign diff    = $signed({1'b0, q8_sat}) - $signed(DIFF_WIDTH'(offset_q));

  always_comb begin
    if (diff > DIST_MAX) begin
      dist_new = DIST_MAX[DIST_WIDTH-1:0];
    end else if (diff < DIST_MIN) begin
      dist_new = DIST_MIN[DIST_WIDTH-1:0];
    end else begin
      dist_new = diff[DIST_WIDTH-1:0];
    end
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    carrier_d   = carrier_q;
    pulses_d    = pulses_q;
    distance_d  = distance_q;
    timed_out_d = timed_out_q;
    done        = 1'b0;
    if (start) begin
      phase_d   = PH_BURST;
      elapsed_d = '0;
      carrier_d = '0;
      pulses_d  = '0;
    end else if (phase_q == PH_BURST) begin
      elapsed_d = elapsed_inc;
      if (carrier_inc >= {1'b0, period_eff}) begin
        carrier_d = '0;
        pulses_d  = pulses_inc;
        // a zero count ends after the first period
        if (pulses_inc >= burst_count_q || pulses_inc == 4'd0) begin
          phase_d = PH_LISTEN;
        end
      end else begin
        carrier_d = carrier_inc[15:0];
      end
    end else if (phase_q == PH_LISTEN) begin
      elapsed_d = elapsed_inc;
      if (falling) begin
        distance_d  = dist_new;
        timed_out_d = 1'b0;
        phase_d     = PH_OVER;
        done        = 1'b1;
      end else if (ELAPSED_WIDTH'(elapsed_inc) > ELAPSED_WIDTH'(timeout_q)
                   || elapsed_inc == ELAPSED_MAX) begin
        distance_d  = '0;
        timed_out_d = 1'b1;
        phase_d     = PH_OVER;
        done        = 1'b1;
      end
    end
  end

  // result fields from the state after this tick
  always_comb begin
    drive_a           = (phase_d == PH_BURST) && (carrier_d < (period_eff >> 1));
    out_d.pad         = '0;
    out_d.distance_q8 = distance_d;
    out_d.timed_out   = timed_out_d;
    out_d.done_res    = done;
    out_d.phase       = phase_d;
    out_d.rx_enable   = (phase_d == PH_LISTEN);
    out_d.tx_power_on = (phase_d == PH_BURST);
    out_d.tx_drive_b  = (phase_d == PH_BURST) && !drive_a;
    out_d.tx_drive_a  = drive_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_READY;
      elapsed_q   <= '0;
      carrier_q   <= '0;
      pulses_q    <= '0;
      distance_q  <= '0;
      echo_prev_q <= 1'b1;
      timed_out_q <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      carrier_q   <= carrier_d;
      pulses_q    <= pulses_d;
      distance_q  <= distance_d;
      echo_prev_q <= echo;
      timed_out_q <= timed_out_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
